[rtl/gear_detect_from_rpm_speed_defines.svh]
// Assertion macros used by the gear detector checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef GEAR_DETECT_FROM_RPM_SPEED_DEFINES_SVH
`define GEAR_DETECT_FROM_RPM_SPEED_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gear detector check failed");

// Consequent must hold in the cycle after the antecedent.
`define GDRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gear detector check failed");

`endif

[rtl/gdrs_pkg.sv]
// Shared types and constants for the gear detector.
// Used by gdrs_sermul and gear_detect_from_rpm_speed; no dependencies.
package gdrs_pkg;

    localparam int MCAND_W     = 28;
    localparam int MPLIER_W    = 17;
    localparam int PROD_W      = MCAND_W + MPLIER_W;
    localparam int DRIVE_STEPS = 12;
    localparam int STEP_CNT_W  = $clog2(MPLIER_W);
    localparam int RPM_SHIFT   = 24;

    localparam logic [2:0] REG_RATIO_FIRST  = 3'd0;
    localparam logic [2:0] REG_RATIO_SECOND = 3'd1;
    localparam logic [2:0] REG_RATIO_THIRD  = 3'd2;
    localparam logic [2:0] REG_RATIO_TOL    = 3'd3;
    localparam logic [2:0] REG_DRIVE_RPM    = 3'd4;
    localparam logic [2:0] REG_STABLE_TIME  = 3'd5;
    localparam logic [2:0] REG_MIN_RPM      = 3'd6;
    localparam logic [2:0] REG_MIN_SPEED    = 3'd7;

    localparam logic [1:0] GEAR_NEUTRAL = 2'd0;
    localparam logic [1:0] GEAR_IDX_LAST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRIVE,
        ST_LOAD,
        ST_GEAR,
        ST_CHECK,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } mul_ctrl_t;

endpackage

[rtl/gear_detect_from_rpm_speed.sv]
// Gear detector: engine rpm against road speed, with a debounce timer.
// Items are processed one at a time by the bit-serial multipliers: 12 steps for drive rpm,
// then a load, 17 steps and a check for each of 3 gears; s_tready is high only when idle.
// The output register lets the next item start while a result waits.
// Reset: async active low; config registers return to defaults, debounce state to neutral.
module gear_detect_from_rpm_speed
    import gdrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // engine_rpm[13:0], road_speed[25:14], time_ms[57:26]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // indicated_gear[1:0], raw_gear[3:2], gear_changed[4]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    state_t state_reg;
    state_t state_next;

    logic [15:0] ratio_first_reg;
    logic [15:0] ratio_second_reg;
    logic [15:0] ratio_third_reg;
    logic [15:0] ratio_tol_reg;
    logic [15:0] drive_rpm_reg;
    logic [15:0] stable_time_reg;
    logic [13:0] min_rpm_reg;
    logic [11:0] min_speed_reg;

    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [STEP_CNT_W-1:0] cnt_next;
    logic [1:0]            gear_idx_reg;
    logic [1:0]            gear_idx_next;
    logic [1:0]            found_reg;
    logic [1:0]            found_next;
    logic                  lower_neg_reg;
    logic                  below_min_reg;
    logic [13:0]           rpm_reg;
    logic [31:0]           time_reg;
    logic [MCAND_W-1:0]    drive_reg;

    logic [1:0]  cand_gear_reg;
    logic [31:0] cand_since_reg;
    logic [31:0] last_confirm_reg;
    logic [1:0]  shown_gear_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [4:0]  out_data_reg;

    logic        accept;
    logic        commit;
    logic [13:0] in_rpm;
    logic [11:0] in_speed;
    logic [31:0] in_time;

    mul_ctrl_t           mul_ctrl;
    logic [MCAND_W-1:0]  mul_mcand;
    logic [MPLIER_W-1:0] up_mplier;
    logic [MPLIER_W-1:0] lo_mplier;
    logic [PROD_W-1:0]   up_prod;
    logic [PROD_W-1:0]   lo_prod;
    logic [MCAND_W-1:0]  drive_val;
    logic [15:0]         ratio_sel;
    logic [MPLIER_W-1:0] upper_ratio;
    logic [MPLIER_W-1:0] lower_diff;
    logic [PROD_W-1:0]   rpm_scaled;
    logic                fits;

    logic [1:0]  raw_gear;
    logic [1:0]  confirmed;
    logic [31:0] since_cand;
    logic [31:0] since_confirm;
    logic [16:0] twice_stable;
    logic        take_confirm;

    assign in_rpm   = s_tdata[13:0];
    assign in_speed = s_tdata[25:14];
    assign in_time  = s_tdata[57:26];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_DECIDE) && (!m_valid_reg || m_tready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_first_reg  <= 16'd14090;
            ratio_second_reg <= 16'd9052;
            ratio_third_reg  <= 16'd5612;
            ratio_tol_reg    <= 16'd819;
            drive_rpm_reg    <= 16'd14592;
            stable_time_reg  <= 16'd500;
            min_rpm_reg      <= 14'd500;
            min_speed_reg    <= 12'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_RATIO_FIRST:  ratio_first_reg  <= cfg_wdata;
                REG_RATIO_SECOND: ratio_second_reg <= cfg_wdata;
                REG_RATIO_THIRD:  ratio_third_reg  <= cfg_wdata;
                REG_RATIO_TOL:    ratio_tol_reg    <= cfg_wdata;
                REG_DRIVE_RPM:    drive_rpm_reg    <= cfg_wdata;
                REG_STABLE_TIME:  stable_time_reg  <= cfg_wdata;
                REG_MIN_RPM:      min_rpm_reg      <= cfg_wdata[13:0];
                REG_MIN_SPEED:    min_speed_reg    <= cfg_wdata[11:0];
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_DRIVE;
            ST_DRIVE:
                if (cnt_reg == '0)
                    state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_GEAR;
            ST_GEAR:
                if (cnt_reg == '0)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = (gear_idx_reg == GEAR_IDX_LAST) ? ST_DECIDE : ST_LOAD;
            ST_DECIDE:
                if (commit)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cnt_next      = cnt_reg;
        gear_idx_next = gear_idx_reg;
        found_next    = found_reg;
        mul_ctrl.load = 1'b0;
        mul_ctrl.step = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mul_ctrl.load = 1'b1;
                    cnt_next      = STEP_CNT_W'(DRIVE_STEPS - 1);
                    gear_idx_next = '0;
                    found_next    = GEAR_NEUTRAL;
                end
            end
            ST_DRIVE, ST_GEAR:
            begin
                mul_ctrl.step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
            end
            ST_LOAD:
            begin
                mul_ctrl.load = 1'b1;
                cnt_next      = STEP_CNT_W'(MPLIER_W - 1);
            end
            ST_CHECK:
            begin
                if (fits && (found_reg == GEAR_NEUTRAL))
                    found_next = gear_idx_reg + 2'd1;
                gear_idx_next = gear_idx_reg + 2'd1;
            end
            ST_DECIDE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            gear_idx_reg <= '0;
            found_reg    <= GEAR_NEUTRAL;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            gear_idx_reg <= gear_idx_next;
            found_reg    <= found_next;
        end
    end

    // operand selection
    always_comb
    begin
        case (gear_idx_reg)
            2'd0:    ratio_sel = ratio_first_reg;
            2'd1:    ratio_sel = ratio_second_reg;
            default: ratio_sel = ratio_third_reg;
        endcase
    end

    assign upper_ratio = {1'b0, ratio_sel} + {1'b0, ratio_tol_reg};
    assign lower_diff  = {1'b0, ratio_sel} - {1'b0, ratio_tol_reg};
    assign drive_val   = (gear_idx_reg == 2'd0) ? up_prod[MCAND_W-1:0] : drive_reg;

    assign mul_mcand = accept ? MCAND_W'(drive_rpm_reg) : drive_val;
    assign up_mplier = accept ? {in_speed, {(MPLIER_W - DRIVE_STEPS){1'b0}}} : upper_ratio;
    assign lo_mplier = lower_diff;

    gdrs_sermul u_mul_up
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mul_ctrl),
        .mcand  (mul_mcand),
        .mplier (up_mplier),
        .prod   (up_prod)
    );

    gdrs_sermul u_mul_lo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mul_ctrl),
        .mcand  (mul_mcand),
        .mplier (lo_mplier),
        .prod   (lo_prod)
    );

    // hold item fields and per-gear operands
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rpm_reg       <= in_rpm;
            time_reg      <= in_time;
            below_min_reg <= (in_rpm < min_rpm_reg) || (in_speed < min_speed_reg);
        end
        if (state_reg == ST_LOAD)
        begin
            lower_neg_reg <= lower_diff[MPLIER_W-1];
            if (gear_idx_reg == 2'd0)
                drive_reg <= up_prod[MCAND_W-1:0];
        end
    end

    // |rpm - ratio*drive| <= tol*drive  as  (ratio-tol)*drive <= rpm <= (ratio+tol)*drive
    assign rpm_scaled = PROD_W'({rpm_reg, {RPM_SHIFT{1'b0}}});
    assign fits = (rpm_scaled <= up_prod) && (lower_neg_reg || (lo_prod <= rpm_scaled));

    // debounce
    assign raw_gear      = below_min_reg ? GEAR_NEUTRAL : found_reg;
    assign since_cand    = time_reg - cand_since_reg;
    assign since_confirm = time_reg - last_confirm_reg;
    assign twice_stable  = {stable_time_reg, 1'b0};
    assign take_confirm  = (raw_gear == cand_gear_reg) && (since_cand >= 32'(stable_time_reg));

    always_comb
    begin
        confirmed = shown_gear_reg;
        if (raw_gear == cand_gear_reg)
        begin
            if (take_confirm)
                confirmed = cand_gear_reg;
        end
        else if (since_confirm > 32'(twice_stable))
            confirmed = GEAR_NEUTRAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_gear_reg    <= GEAR_NEUTRAL;
            cand_since_reg   <= '0;
            last_confirm_reg <= '0;
            shown_gear_reg   <= GEAR_NEUTRAL;
        end
        else if (commit)
        begin
            shown_gear_reg <= confirmed;
            if (raw_gear != cand_gear_reg)
            begin
                cand_gear_reg  <= raw_gear;
                cand_since_reg <= time_reg;
            end
            if (take_confirm)
                last_confirm_reg <= time_reg;
        end
    end

    // output register
    always_comb
    begin
        if (commit)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            out_data_reg <= {(confirmed != shown_gear_reg), raw_gear, confirmed};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

endmodule

[rtl/gdrs_sermul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle while step is set, MSB first.
// Depends on gdrs_pkg for widths and the control struct.
module gdrs_sermul
    import gdrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mul_ctrl_t           ctrl,
    input  logic [MCAND_W-1:0]  mcand,
    input  logic [MPLIER_W-1:0] mplier,
    output logic [PROD_W-1:0]   prod
);

    logic [MCAND_W-1:0]  mcand_reg;
    logic [MCAND_W-1:0]  mcand_next;
    logic [MPLIER_W-1:0] mplier_reg;
    logic [MPLIER_W-1:0] mplier_next;
    logic [PROD_W-1:0]   acc_reg;
    logic [PROD_W-1:0]   acc_next;
    logic                busy_reg;

    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (ctrl.load)
        begin
            mcand_next  = mcand;
            mplier_next = mplier;
            acc_next    = '0;
        end
        else if (ctrl.step)
        begin
            mplier_next = {mplier_reg[MPLIER_W-2:0], 1'b0};
            acc_next    = {acc_reg[PROD_W-2:0], 1'b0}
                        + (mplier_reg[MPLIER_W-1] ? PROD_W'(mcand_reg) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    // track whether a product has been started since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (ctrl.load)
            busy_reg <= 1'b1;
    end

    assign prod = busy_reg ? acc_reg : '0;

endmodule

[rtl/gdrs_checker.sv]
// Port-level checks for the gear detector, bound to the top level.
// Depends on gear_detect_from_rpm_speed_defines.svh for the assertion macros.
`include "gear_detect_from_rpm_speed_defines.svh"

module gdrs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        cfg_we,
    input logic [2:0]  cfg_addr,
    input logic [15:0] cfg_wdata
);

    `GDRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `GDRS_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[7:5] == 3'd0)
    `GDRS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `GDRS_ASSERT_NOW(a_new_gear_is_raw, m_tvalid && m_tdata[4] && (m_tdata[1:0] != 2'd0),
        m_tdata[1:0] == m_tdata[3:2])

endmodule

bind gear_detect_from_rpm_speed gdrs_checker u_gdrs_checker (.*);
